// ----- hw/rtl/stwm_pkg.sv -----
// Package with the types, codes and field widths of the two-wire sensor measurement master.
package stwm_pkg;

	localparam int CmdW      = 8;
	localparam int RawW      = 16;
	localparam int ErrW      = 2;
	localparam int TickW     = 16;
	localparam int PollW     = 8;
	localparam int BitCntW   = 4;
	localparam int CfgIdxW   = 2;
	localparam int CfgDataW  = 16;
	localparam int InDataW   = 16;
	localparam int OutDataW  = 24;

	localparam logic [CfgIdxW-1:0] CfgHalfPeriod   = 2'd0;
	localparam logic [CfgIdxW-1:0] CfgAckRelease   = 2'd1;
	localparam logic [CfgIdxW-1:0] CfgPollInterval = 2'd2;
	localparam logic [CfgIdxW-1:0] CfgTimeoutPolls = 2'd3;

	localparam logic [7:0]  HalfPeriodReset   = 8'd1;
	localparam logic [7:0]  AckReleaseReset   = 8'd10;
	localparam logic [15:0] PollIntervalReset = 16'd10000;
	localparam logic [7:0]  TimeoutPollsReset = 8'd100;

	localparam logic [BitCntW-1:0] LastBitOfByte = 4'd7;
	localparam logic [BitCntW-1:0] LastBitOfWord = 4'd15;

	typedef enum logic [ErrW-1:0] {
		ERR_NONE        = 2'd0,
		ERR_NO_CMD_ACK  = 2'd1,
		ERR_NOT_RELEASE = 2'd2,
		ERR_TIMEOUT     = 2'd3
	} err_t;

	typedef enum logic [15:0] {
		PH_IDLE   = 16'h0001,
		PH_S0     = 16'h0002,
		PH_S1     = 16'h0004,
		PH_S2     = 16'h0008,
		PH_S3     = 16'h0010,
		PH_S4     = 16'h0020,
		PH_CB_HI  = 16'h0040,
		PH_CB_LO  = 16'h0080,
		PH_ACK_HI = 16'h0100,
		PH_ACK_LO = 16'h0200,
		PH_WAIT   = 16'h0400,
		PH_RD_HI  = 16'h0800,
		PH_RD_LO  = 16'h1000,
		PH_MA_HI  = 16'h2000,
		PH_MA_LO  = 16'h4000,
		PH_CRC_HI = 16'h8000
	} phase_t;

	typedef struct packed {
		logic [RawW-1:0] raw_value;
		err_t            error_code;
		logic            done_res;
		logic            busy_res;
		logic            data_pull_low;
		logic            clock_level;
	} result_t;

endpackage

// ----- hw/rtl/sensor_two_wire_measure_master.sv -----
// Top level of the two-wire sensor measurement master: sequencer, configuration and stream ports.
//
// Every input transfer is one tick of the bus time base and produces exactly one result
// transfer holding the clock and data-line levels after that tick together with the busy,
// done, error and raw-value status. The whole sequencer step is one pass of logic from the
// state registers to the result register, so one tick is taken every cycle while the result
// side keeps up; the block stalls only when the result register is full. Segment lengths come
// from the configuration registers, written by the user while idle; the block does not check it.
module sensor_two_wire_measure_master
	import stwm_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [CfgIdxW-1:0]  cfg_index,
	input  logic [CfgDataW-1:0] cfg_data,
	input  logic                s_tvalid,
	output logic                s_tready,
	// start_req [0], command [8:1], data_level [9], zero fill [15:10]
	input  logic [InDataW-1:0]  s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// clock_level [0], data_pull_low [1], busy_res [2], done_res [3], error_code [5:4],
	// raw_value [21:6], zero fill [23:22]
	output logic [OutDataW-1:0] m_tdata
);

	logic [7:0]  half_period_q;
	logic [7:0]  ack_release_q;
	logic [15:0] poll_interval_q;
	logic [7:0]  timeout_polls_q;

	phase_t               phase_q, phase_n;
	logic [BitCntW-1:0]   bit_count_q, bit_count_n;
	logic [TickW-1:0]     tick_count_q, tick_count_n;
	logic [PollW-1:0]     poll_count_q, poll_count_n;
	logic [RawW-1:0]      shift_word_q, shift_word_n;
	logic [CmdW-1:0]      command_q, command_n;
	logic                 clock_q, clock_n;
	logic                 pull_q, pull_n;

	logic                 accept;
	logic                 start_req;
	logic [CmdW-1:0]      command;
	logic                 data_level;
	logic [TickW-1:0]     duration;
	logic [TickW:0]       tick_inc;
	logic [PollW-1:0]     poll_inc;
	logic [7:0]           timeout_min;
	logic                 entering;
	logic                 done;
	err_t                 err;
	logic [RawW-1:0]      raw;
	logic [2:0]           cmd_sel;
	result_t              result;
	result_t              result_q;

	assign start_req  = s_tdata[0];
	assign command    = s_tdata[8:1];
	assign data_level = s_tdata[9];

	assign s_tready = !m_tvalid || m_tready;
	assign accept   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_period_q   <= HalfPeriodReset;
			ack_release_q   <= AckReleaseReset;
			poll_interval_q <= PollIntervalReset;
			timeout_polls_q <= TimeoutPollsReset;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CfgHalfPeriod:   half_period_q   <= cfg_data[7:0];
				CfgAckRelease:   ack_release_q   <= cfg_data[7:0];
				CfgPollInterval: poll_interval_q <= cfg_data;
				CfgTimeoutPolls: timeout_polls_q <= cfg_data[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (phase_q == PH_ACK_LO) begin
			duration = {8'd0, ack_release_q};
		end else if (phase_q == PH_WAIT) begin
			duration = poll_interval_q;
		end else begin
			duration = {8'd0, half_period_q};
		end
		if (duration == '0) begin
			duration = TickW'(1);
		end
	end

	assign tick_inc    = {1'b0, tick_count_q} + (TickW+1)'(1);
	assign poll_inc    = poll_count_q + PollW'(1);
	assign timeout_min = (timeout_polls_q == 8'd0) ? 8'd1 : timeout_polls_q;

	always_comb begin
		phase_n      = phase_q;
		bit_count_n  = bit_count_q;
		tick_count_n = tick_count_q;
		poll_count_n = poll_count_q;
		shift_word_n = shift_word_q;
		command_n    = command_q;
		entering     = 1'b0;
		done         = 1'b0;
		err          = ERR_NONE;
		raw          = '0;

		if (phase_q == PH_IDLE) begin
			if (start_req) begin
				command_n    = command;
				bit_count_n  = '0;
				poll_count_n = '0;
				shift_word_n = '0;
				phase_n      = PH_S0;
				entering     = 1'b1;
			end
		end else if (tick_inc < {1'b0, duration}) begin
			tick_count_n = tick_inc[TickW-1:0];
		end else begin
			entering = 1'b1;
			unique case (phase_q)
				PH_S0: phase_n = PH_S1;
				PH_S1: phase_n = PH_S2;
				PH_S2: phase_n = PH_S3;
				PH_S3: phase_n = PH_S4;
				PH_S4: begin
					bit_count_n = '0;
					phase_n     = PH_CB_HI;
				end
				PH_CB_HI: phase_n = PH_CB_LO;
				PH_CB_LO: begin
					bit_count_n = bit_count_q + BitCntW'(1);
					phase_n     = (bit_count_q >= LastBitOfByte) ? PH_ACK_HI : PH_CB_HI;
				end
				PH_ACK_HI: begin
					if (data_level) begin
						done = 1'b1;
						err  = ERR_NO_CMD_ACK;
					end else begin
						phase_n = PH_ACK_LO;
					end
				end
				PH_ACK_LO: begin
					if (!data_level) begin
						done = 1'b1;
						err  = ERR_NOT_RELEASE;
					end else begin
						poll_count_n = '0;
						phase_n      = PH_WAIT;
					end
				end
				PH_WAIT: begin
					if (!data_level) begin
						bit_count_n = '0;
						phase_n     = PH_RD_HI;
					end else begin
						poll_count_n = poll_inc;
						if (poll_inc >= timeout_min) begin
							done = 1'b1;
							err  = ERR_TIMEOUT;
						end else begin
							phase_n = PH_WAIT;
						end
					end
				end
				PH_RD_HI: begin
					shift_word_n = {shift_word_q[RawW-2:0], data_level};
					phase_n      = PH_RD_LO;
				end
				PH_RD_LO: begin
					bit_count_n = bit_count_q + BitCntW'(1);
					if (bit_count_q == LastBitOfByte) begin
						phase_n = PH_MA_HI;
					end else if (bit_count_q == LastBitOfWord) begin
						phase_n = PH_CRC_HI;
					end else begin
						phase_n = PH_RD_HI;
					end
				end
				PH_MA_HI: phase_n = PH_MA_LO;
				PH_MA_LO: phase_n = PH_RD_HI;
				PH_CRC_HI: begin
					done = 1'b1;
					raw  = shift_word_q;
				end
				default: done = 1'b1;
			endcase
			if (done) begin
				phase_n = PH_IDLE;
				if (err != ERR_NONE) begin
					raw = '0;
				end
			end
		end
		if (entering) begin
			tick_count_n = '0;
		end
	end

	// Line levels follow the phase being entered; the command bit is sent inverted as pull-low.
	assign cmd_sel = 3'd7 - bit_count_n[2:0];

	always_comb begin
		clock_n = clock_q;
		pull_n  = pull_q;
		if (entering) begin
			clock_n      = 1'b0;
			pull_n       = 1'b0;
			unique case (phase_n)
				PH_S1: begin
					clock_n = 1'b1;
					pull_n  = 1'b1;
				end
				PH_S2:     pull_n  = 1'b1;
				PH_S3:     clock_n = 1'b1;
				PH_CB_HI: begin
					clock_n = 1'b1;
					pull_n  = !command_n[cmd_sel];
				end
				PH_CB_LO:  pull_n  = !command_n[cmd_sel];
				PH_ACK_HI: clock_n = 1'b1;
				PH_RD_HI:  clock_n = 1'b1;
				PH_MA_HI: begin
					clock_n = 1'b1;
					pull_n  = 1'b1;
				end
				PH_CRC_HI: clock_n = 1'b1;
				default: ;
			endcase
		end
	end

	always_comb begin
		result.clock_level   = clock_n;
		result.data_pull_low = pull_n;
		result.busy_res      = (phase_n != PH_IDLE);
		result.done_res      = done;
		result.error_code    = err;
		result.raw_value     = raw;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			bit_count_q  <= '0;
			tick_count_q <= '0;
			poll_count_q <= '0;
			shift_word_q <= '0;
			command_q    <= '0;
			clock_q      <= 1'b0;
			pull_q       <= 1'b0;
			m_tvalid     <= 1'b0;
		end else begin
			if (accept) begin
				phase_q      <= phase_n;
				bit_count_q  <= bit_count_n;
				tick_count_q <= tick_count_n;
				poll_count_q <= poll_count_n;
				shift_word_q <= shift_word_n;
				command_q    <= command_n;
				clock_q      <= clock_n;
				pull_q       <= pull_n;
				m_tvalid     <= 1'b1;
			end else if (m_tready) begin
				m_tvalid     <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign m_tdata = {2'b00, result_q};

endmodule

// ----- tb/tb_top.sv -----
// Self-checking testbench of the two-wire sensor measurement master, with its own sequencer predictor.
module tb_top;
	import stwm_pkg::*;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int CycleLimit = 1_000_000;
	localparam int HoldCycles = 300;

	typedef struct {
		logic       st;
		logic [7:0] cmd;
		logic       d;
		int         reps;
		logic       typed;
		result_t    want;
	} row_t;

	typedef struct {
		logic [7:0]  half;
		logic [7:0]  ack;
		logic [15:0] poll;
		logic [7:0]  tmo;
		int          snd;
		int          rcv;
		int          start_pct;
		int          ready_pct;
		int          ticks;
	} mode_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [CfgIdxW-1:0]  cfg_index;
	logic [CfgDataW-1:0] cfg_data;
	logic                s_tvalid;
	logic                s_tready;
	logic [InDataW-1:0]  s_tdata;
	logic                m_tvalid;
	logic                m_tready;
	logic [OutDataW-1:0] m_tdata;

	result_t line_status_q[$];
	int      faults = 0;
	int      snd_idle = 0;
	int      rcv_stall = 0;
	logic    hold_req = 1'b0;

	logic [7:0]         cf_half;
	logic [7:0]         cf_ack;
	logic [15:0]        cf_poll;
	logic [7:0]         cf_tmo;
	phase_t             seq_phase;
	logic [BitCntW-1:0] seq_bits;
	logic [TickW-1:0]   seq_ticks;
	logic [PollW-1:0]   seq_polls;
	logic [RawW-1:0]    seq_shift;
	logic [CmdW-1:0]    seq_cmd;
	logic               seq_scl;
	logic               seq_sda_low;

	sensor_two_wire_measure_master dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic result_t lines(logic scl, logic sda, logic busy, logic done, err_t e);
		result_t r;
		r = '0;
		r.clock_level = scl;
		r.data_pull_low = sda;
		r.busy_res = busy;
		r.done_res = done;
		r.error_code = e;
		return r;
	endfunction

	function automatic logic [15:0] seq_span(phase_t p);
		logic [15:0] v;
		if (p == PH_ACK_LO) v = {8'd0, cf_ack};
		else if (p == PH_WAIT) v = cf_poll;
		else v = {8'd0, cf_half};
		return (v == 16'd0) ? 16'd1 : v;
	endfunction

	function automatic void seq_enter(phase_t p);
		seq_phase = p;
		seq_ticks = '0;
		seq_scl = 1'b0;
		seq_sda_low = 1'b0;
		case (p)
			PH_S1: begin
				seq_scl = 1'b1;
				seq_sda_low = 1'b1;
			end
			PH_S2: seq_sda_low = 1'b1;
			PH_CB_HI, PH_CB_LO: begin
				seq_scl = (p == PH_CB_HI);
				seq_sda_low = ~seq_cmd[3'd7 - seq_bits[2:0]];
			end
			PH_MA_HI: begin
				seq_scl = 1'b1;
				seq_sda_low = 1'b1;
			end
			PH_S3, PH_ACK_HI, PH_RD_HI, PH_CRC_HI: seq_scl = 1'b1;
			default: ;
		endcase
	endfunction

	function automatic result_t sequencer_tick(logic st, logic [7:0] cmd, logic d);
		result_t            r;
		logic               fin;
		err_t               e;
		logic [RawW-1:0]    raw;
		logic [BitCntW-1:0] old;
		logic [PollW-1:0]   limit;
		fin = 1'b0;
		e = ERR_NONE;
		raw = '0;
		old = seq_bits;
		limit = (cf_tmo == 8'd0) ? 8'd1 : cf_tmo;
		if (seq_phase == PH_IDLE) begin
			if (st) begin
				seq_cmd = cmd;
				seq_bits = '0;
				seq_polls = '0;
				seq_shift = '0;
				seq_enter(PH_S0);
			end
		end else if (int'(seq_ticks) + 1 < int'(seq_span(seq_phase))) begin
			seq_ticks++;
		end else begin
			case (seq_phase)
				PH_S0: seq_enter(PH_S1);
				PH_S1: seq_enter(PH_S2);
				PH_S2: seq_enter(PH_S3);
				PH_S3: seq_enter(PH_S4);
				PH_S4: begin
					seq_bits = '0;
					seq_enter(PH_CB_HI);
				end
				PH_CB_HI: seq_enter(PH_CB_LO);
				PH_CB_LO: begin
					seq_bits = old + 4'd1;
					seq_enter((old >= LastBitOfByte) ? PH_ACK_HI : PH_CB_HI);
				end
				PH_ACK_HI: begin
					if (d) begin
						fin = 1'b1;
						e = ERR_NO_CMD_ACK;
					end else seq_enter(PH_ACK_LO);
				end
				PH_ACK_LO: begin
					if (!d) begin
						fin = 1'b1;
						e = ERR_NOT_RELEASE;
					end else begin
						seq_polls = '0;
						seq_enter(PH_WAIT);
					end
				end
				PH_WAIT: begin
					if (!d) begin
						seq_bits = '0;
						seq_enter(PH_RD_HI);
					end else begin
						seq_polls++;
						if (seq_polls >= limit) begin
							fin = 1'b1;
							e = ERR_TIMEOUT;
						end else seq_enter(PH_WAIT);
					end
				end
				PH_RD_HI: begin
					seq_shift = {seq_shift[RawW-2:0], d};
					seq_enter(PH_RD_LO);
				end
				PH_RD_LO: begin
					seq_bits = old + 4'd1;
					if (old == LastBitOfByte) seq_enter(PH_MA_HI);
					else if (old == LastBitOfWord) seq_enter(PH_CRC_HI);
					else seq_enter(PH_RD_HI);
				end
				PH_MA_HI: seq_enter(PH_MA_LO);
				PH_MA_LO: seq_enter(PH_RD_HI);
				default: begin
					fin = 1'b1;
					raw = seq_shift;
				end
			endcase
			if (fin) begin
				seq_enter(PH_IDLE);
				if (e != ERR_NONE) raw = '0;
			end
		end
		r = lines(seq_scl, seq_sda_low, seq_phase != PH_IDLE, fin, e);
		r.raw_value = raw;
		return r;
	endfunction

	task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		case (idx)
			CfgHalfPeriod: cf_half = val[7:0];
			CfgAckRelease: cf_ack = val[7:0];
			CfgPollInterval: cf_poll = val;
			default: cf_tmo = val[7:0];
		endcase
	endtask

	task automatic send_tick(input logic st, input logic [7:0] cmd, input logic d,
			input logic typed, input result_t want);
		result_t pred;
		while ($urandom_range(99) < snd_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {6'd0, d, cmd, st};
		do @(posedge clk); while (!s_tready);
		pred = sequencer_tick(st, cmd, d);
		line_status_q.push_back(typed ? want : pred);
	endtask

	initial begin
		int      hold_left;
		bit      hold_spent;
		result_t got;
		result_t want;
		hold_left = 0;
		hold_spent = 1'b0;
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				got = result_t'(m_tdata[21:0]);
				if (line_status_q.size() == 0) begin
					faults++;
					if (faults <= 10) $display("unexpected result transfer %h", m_tdata);
				end else begin
					want = line_status_q.pop_front();
					if (got !== want || m_tdata[23:22] !== 2'b00) begin
						faults++;
						if (faults <= 10)
							$display({"result mismatch: expected scl=%b pull=%b busy=%b done=%b",
								" err=%0d raw=%h, got scl=%b pull=%b busy=%b done=%b err=%0d",
								" raw=%h fill=%b"},
								want.clock_level, want.data_pull_low, want.busy_res,
								want.done_res, want.error_code, want.raw_value,
								got.clock_level, got.data_pull_low, got.busy_res,
								got.done_res, got.error_code, got.raw_value, m_tdata[23:22]);
					end
				end
			end
			if (hold_req && !hold_spent) begin
				hold_left = HoldCycles;
				hold_spent = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else m_tready <= ($urandom_range(99) >= rcv_stall);
		end
	end

	initial begin
		int cycles;
		cycles = 0;
		while (cycles < CycleLimit) begin
			@(posedge clk);
			cycles++;
		end
		$display("tb_top: done, errors");
		$finish;
	end

	initial begin
		row_t  opening[6];
		mode_t modes[7];
		int    n;
		logic  st;
		logic  d;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cf_half = HalfPeriodReset;
		cf_ack = AckReleaseReset;
		cf_poll = PollIntervalReset;
		cf_tmo = TimeoutPollsReset;
		seq_cmd = '0;
		seq_bits = '0;
		seq_polls = '0;
		seq_shift = '0;
		seq_enter(PH_IDLE);

		// The opening sequence sends command A5, ignores a second start while busy,
		// and ends when the sensor does not acknowledge the command.
		opening = '{
			'{1'b0, 8'h00, 1'b0, 1, 1'b1, lines(1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE)},
			'{1'b0, 8'hFF, 1'b1, 1, 1'b1, lines(1'b0, 1'b0, 1'b0, 1'b0, ERR_NONE)},
			'{1'b1, 8'hA5, 1'b1, 1, 1'b1, lines(1'b0, 1'b0, 1'b1, 1'b0, ERR_NONE)},
			'{1'b1, 8'h00, 1'b0, 4, 1'b0, '0},
			'{1'b0, 8'hFF, 1'b0, 17, 1'b0, '0},
			'{1'b0, 8'h00, 1'b1, 1, 1'b1, lines(1'b0, 1'b0, 1'b0, 1'b1, ERR_NO_CMD_ACK)}
		};
		modes = '{
			'{8'd1, 8'd1, 16'd1, 8'd1, 0, 0, 40, 50, 60},
			'{8'd1, 8'd3, 16'd4, 8'd3, 86, 0, 40, 40, 20},
			'{8'd1, 8'd2, 16'd3, 8'd5, 0, 86, 40, 40, 20},
			'{8'd2, 8'd1, 16'd2, 8'd2, 28, 28, 40, 40, 20},
			'{8'd0, 8'd0, 16'd0, 8'd0, 0, 0, 40, 40, 20},
			'{8'd1, 8'd1, 16'd1, 8'd255, 0, 0, 100, 0, 1},
			'{8'd1, 8'd5, 16'd2, 8'd8, 28, 28, 40, 45, 20}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (opening[i])
			for (int k = 0; k < opening[i].reps; k++)
				send_tick(opening[i].st, opening[i].cmd, opening[i].d, opening[i].typed,
					opening[i].want);

		for (int m = 0; m < 7; m++) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (line_status_q.size() != 0);
			snd_idle = modes[m].snd;
			rcv_stall = modes[m].rcv;
			write_reg(CfgHalfPeriod, {8'($urandom_range(255)), modes[m].half});
			write_reg(CfgAckRelease, {8'($urandom_range(255)), modes[m].ack});
			write_reg(CfgPollInterval, modes[m].poll);
			write_reg(CfgTimeoutPolls, {8'($urandom_range(255)), modes[m].tmo});
			cfg_we <= 1'b0;
			n = 0;
			while (n < modes[m].ticks || seq_phase != PH_IDLE) begin
				if (n >= modes[m].ticks) st = 1'b0;
				else if (seq_phase == PH_IDLE) st = ($urandom_range(99) < modes[m].start_pct);
				else st = 1'($urandom_range(1));
				case (seq_phase)
					PH_ACK_HI: d = ($urandom_range(99) >= 92);
					PH_ACK_LO: d = ($urandom_range(99) < 92);
					PH_WAIT: d = ($urandom_range(99) >= modes[m].ready_pct);
					default: d = 1'($urandom_range(1));
				endcase
				send_tick(st, 8'($urandom_range(255)), d, 1'b0, '0);
				n++;
				if (m == 0 && n == 15) hold_req <= 1'b1;
				if (m == 0 && n == 40) begin
					s_tvalid <= 1'b0;
					do @(posedge clk); while (line_status_q.size() != 0);
				end
			end
		end

		s_tvalid <= 1'b0;
		do @(posedge clk); while (line_status_q.size() != 0);
		repeat (8) @(posedge clk);
		if (faults == 0) $display("tb_top: done, clean");
		else $display("tb_top: done, errors");
		$finish;
	end

endmodule
